### design/jslsp_pkg.sv
package jslsp_pkg;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_TARGET = 2'd1;
   localparam logic [1:0] CMD_LIMITS = 2'd2;

   localparam logic [1:0] CSR_PWM_MIN  = 2'd0;
   localparam logic [1:0] CSR_PWM_MAX  = 2'd1;
   localparam logic [1:0] CSR_MAX_STEP = 2'd2;

   localparam logic [11:0] PWM_MIN_RESET  = 12'd102;
   localparam logic [11:0] PWM_MAX_RESET  = 12'd512;
   localparam logic [10:0] MAX_STEP_RESET = 11'd20;

   localparam logic [10:0] FULL_SCALE  = 11'd1800;
   localparam logic [10:0] ANGLE_RESET = 11'd900;

   // floor(2^23 / 1800), exact to within one for products below 2^23
   localparam int          DIV_SHIFT = 23;
   localparam logic [12:0] DIV_RECIP = 13'd4660;

   typedef struct packed {
      logic [10:0] low;
      logic [10:0] high;
      logic        mirrored;
      logic        wired;
      logic [3:0]  channel;
   } lim_type;

   localparam lim_type LIM_RESET = '{low: 11'd0, high: 11'd1800, mirrored: 1'b0,
                                     wired: 1'b0, channel: 4'd0};

   typedef struct packed {
      logic take;
      logic clr;
      logic rd;
      logic calc;
      logic mul;
      logic load;
      logic inc;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic last;
   } dp_stat_type;

endpackage

### design/joint_slew_limit_servo_pwm.sv
// set target and load limits transfers are taken in the idle state without stalling the input
// a tick steps each joint in turn through read, slew/clamp/scale, divide and output
// a tick stalls the input until the last joint's result is loaded into the output register
// the output register lets the next command in while the last result waits
// synchronous active-high reset: registers to defaults, per-joint valid bits cleared so
// every joint reads its reset angles and limits, no clearing pass
module joint_slew_limit_servo_pwm
   import jslsp_pkg::*;
#(
   parameter int JOINTS = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_joint,
   input  logic [10:0] req_angle,
   input  logic [10:0] req_limit_low,
   input  logic [10:0] req_limit_high,
   input  logic        req_reversed,
   input  logic        req_present,
   input  logic [3:0]  req_channel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_out_joint,
   output logic [3:0]  rsp_out_channel,
   output logic [11:0] rsp_pulse,
   output logic        rsp_driven,
   output logic        rsp_last
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   jslsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   jslsp_dpath #(
      .JOINTS (JOINTS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_joint       (req_joint),
      .req_angle       (req_angle),
      .req_limit_low   (req_limit_low),
      .req_limit_high  (req_limit_high),
      .req_reversed    (req_reversed),
      .req_present     (req_present),
      .req_channel     (req_channel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_joint   (rsp_out_joint),
      .rsp_out_channel (rsp_out_channel),
      .rsp_pulse       (rsp_pulse),
      .rsp_driven      (rsp_driven),
      .rsp_last        (rsp_last)
   );

endmodule

### design/jslsp_ctrl.sv
module jslsp_ctrl
   import jslsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_cmd,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        req_stall
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_CALC = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_cmd == CMD_TICK) begin
                  cmd.clr  = 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               if (stat.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.inc  = 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_last_ends_tick: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && stat.last) |=> (state_ff == ST_IDLE))
      else $error("tick did not end after last joint");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !stat.out_free) |=> (state_ff == ST_EMIT))
      else $error("result step left while output busy");

endmodule

### design/jslsp_dpath.sv
module jslsp_dpath
   import jslsp_pkg::*;
#(
   parameter int JOINTS = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_joint,
   input  logic [10:0] req_angle,
   input  logic [10:0] req_limit_low,
   input  logic [10:0] req_limit_high,
   input  logic        req_reversed,
   input  logic        req_present,
   input  logic [3:0]  req_channel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_out_joint,
   output logic [3:0]  rsp_out_channel,
   output logic [11:0] rsp_pulse,
   output logic        rsp_driven,
   output logic        rsp_last
);

   localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam logic [JW-1:0] LAST_IDX = JW'(JOINTS - 1);

   // configuration
   logic [11:0] pwm_min_ff, pwm_max_ff;
   logic [10:0] max_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_min_ff  <= PWM_MIN_RESET;
         pwm_max_ff  <= PWM_MAX_RESET;
         max_step_ff <= MAX_STEP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PWM_MIN:  pwm_min_ff  <= csr_wdata;
            CSR_PWM_MAX:  pwm_max_ff  <= csr_wdata;
            CSR_MAX_STEP: max_step_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // joint stores
   logic [10:0] cur_mem_ff [JOINTS];
   logic [10:0] tgt_mem_ff [JOINTS];
   lim_type     lim_mem_ff [JOINTS];
   logic [JOINTS-1:0] cur_vld_ff, tgt_vld_ff, lim_vld_ff;

   logic [JW-1:0] idx_ff;
   logic [JW-1:0] wr_idx;
   logic          in_range;
   logic          wr_tgt, wr_lim, wr_cur;
   logic [10:0]   sat_angle, sat_low, sat_high;
   logic [10:0]   cur_new;
   lim_type       lim_wr;

   assign wr_idx    = JW'(req_joint);
   assign in_range  = ({2'b00, req_joint} < 7'(JOINTS));
   assign wr_tgt    = cmd.take && (req_cmd == CMD_TARGET) && in_range;
   assign wr_lim    = cmd.take && (req_cmd == CMD_LIMITS) && in_range;
   assign wr_cur    = cmd.calc;
   assign sat_angle = (req_angle > FULL_SCALE) ? FULL_SCALE : req_angle;
   assign sat_low   = (req_limit_low > FULL_SCALE) ? FULL_SCALE : req_limit_low;
   assign sat_high  = (req_limit_high > FULL_SCALE) ? FULL_SCALE : req_limit_high;

   always_comb begin
      lim_wr.low      = sat_low;
      lim_wr.high     = sat_high;
      lim_wr.mirrored = req_reversed;
      lim_wr.wired    = req_present;
      lim_wr.channel  = req_channel;
   end

   always_ff @(posedge clock) begin
      if (wr_tgt) begin
         tgt_mem_ff[wr_idx] <= sat_angle;
      end
      if (wr_lim) begin
         lim_mem_ff[wr_idx] <= lim_wr;
      end
      if (wr_cur) begin
         cur_mem_ff[idx_ff] <= cur_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= '0;
         tgt_vld_ff <= '0;
         lim_vld_ff <= '0;
      end else begin
         if (wr_tgt) begin
            tgt_vld_ff[wr_idx] <= 1'b1;
         end
         if (wr_lim) begin
            lim_vld_ff[wr_idx] <= 1'b1;
         end
         if (wr_cur) begin
            cur_vld_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // joint counter
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         idx_ff <= '0;
      end else if (cmd.inc) begin
         idx_ff <= idx_ff + JW'(1);
      end
   end

   // registered reads
   logic [10:0] cur_q_ff, tgt_q_ff;
   lim_type     lim_q_ff;
   logic        cur_v_ff, tgt_v_ff, lim_v_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         cur_q_ff <= cur_mem_ff[idx_ff];
         tgt_q_ff <= tgt_mem_ff[idx_ff];
         lim_q_ff <= lim_mem_ff[idx_ff];
         cur_v_ff <= cur_vld_ff[idx_ff];
         tgt_v_ff <= tgt_vld_ff[idx_ff];
         lim_v_ff <= lim_vld_ff[idx_ff];
      end
   end

   // slew, clamp, mirror, scale
   logic [10:0] cur_a, tgt_a, diff, a_clamp, a_mir;
   logic [11:0] sum_up, span;
   lim_type     lim_a;
   logic [22:0] prod_in, prod_ff;
   logic        wired_ff;
   logic [3:0]  chan_ff;

   assign cur_a  = cur_v_ff ? cur_q_ff : ANGLE_RESET;
   assign tgt_a  = tgt_v_ff ? tgt_q_ff : ANGLE_RESET;
   assign lim_a  = lim_v_ff ? lim_q_ff : LIM_RESET;
   assign sum_up = {1'b0, cur_a} + {1'b0, max_step_ff};

   always_comb begin
      if (tgt_a >= cur_a) begin
         diff    = tgt_a - cur_a;
         cur_new = (diff <= max_step_ff) ? tgt_a : sum_up[10:0];
      end else begin
         diff    = cur_a - tgt_a;
         cur_new = (diff <= max_step_ff) ? tgt_a : (cur_a - max_step_ff);
      end
      if (cur_new < lim_a.low) begin
         a_clamp = lim_a.low;
      end else if (cur_new > lim_a.high) begin
         a_clamp = lim_a.high;
      end else begin
         a_clamp = cur_new;
      end
   end

   assign a_mir   = lim_a.mirrored ? (FULL_SCALE - a_clamp) : a_clamp;
   assign span    = (pwm_max_ff > pwm_min_ff) ? (pwm_max_ff - pwm_min_ff) : 12'd0;
   assign prod_in = {12'd0, a_mir} * {11'd0, span};

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         prod_ff  <= prod_in;
         wired_ff <= lim_a.wired;
         chan_ff  <= lim_a.channel;
      end
   end

   // divide by full scale: reciprocal estimate, then one correction
   logic [35:0] recip_prod;
   logic [12:0] q0_ff;

   assign recip_prod = {13'd0, prod_ff} * {23'd0, DIV_RECIP};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         q0_ff <= recip_prod[35:DIV_SHIFT];
      end
   end

   logic [22:0] q0_back, rem;
   logic [12:0] quot;
   logic [11:0] pulse_sum;

   assign q0_back   = {10'd0, q0_ff} * 23'd1800;
   assign rem       = prod_ff - q0_back;
   assign quot      = q0_ff + {12'd0, (rem >= 23'd1800)};
   assign pulse_sum = pwm_min_ff + quot[11:0];

   // output register
   logic        rsp_valid_ff;
   logic [4:0]  rsp_joint_ff;
   logic [3:0]  rsp_chan_ff;
   logic [11:0] rsp_pulse_ff;
   logic        rsp_driven_ff, rsp_last_ff;
   logic        is_last;

   assign is_last = (idx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_joint_ff  <= 5'(idx_ff);
         rsp_chan_ff   <= chan_ff;
         rsp_pulse_ff  <= wired_ff ? pulse_sum : 12'd0;
         rsp_driven_ff <= wired_ff;
         rsp_last_ff   <= is_last;
      end
   end

   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.last       = is_last;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_joint   = rsp_joint_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_pulse       = rsp_pulse_ff;
   assign rsp_driven      = rsp_driven_ff;
   assign rsp_last        = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("untaken result overwritten");

   a_undriven_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_driven_ff) |-> (rsp_pulse_ff == 12'd0))
      else $error("pulse set on undriven joint");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (rem < 23'd3600))
      else $error("reciprocal estimate off by more than one");

endmodule

### verif/joint_pulse_checker.sv
`timescale 1ns / 100ps

module joint_pulse_checker
   import jslsp_pkg::*;
#(
   parameter int JOINTS = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_joint,
   input  logic [10:0] req_angle,
   input  logic [10:0] req_limit_low,
   input  logic [10:0] req_limit_high,
   input  logic        req_reversed,
   input  logic        req_present,
   input  logic [3:0]  req_channel,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [4:0]  rsp_out_joint,
   input  logic [3:0]  rsp_out_channel,
   input  logic [11:0] rsp_pulse,
   input  logic        rsp_driven,
   input  logic        rsp_last,
   output int unsigned errors,
   output int unsigned pending,
   output int unsigned compared
);

   typedef struct packed {
      logic [4:0]  joint;
      logic [3:0]  channel;
      logic [11:0] pulse;
      logic        driven;
      logic        last;
   } joint_result_type;

   logic [11:0]      pwm_min_q;
   logic [11:0]      pwm_max_q;
   logic [10:0]      max_step_q;
   logic [10:0]      cur_angle [JOINTS];
   logic [10:0]      tgt_angle [JOINTS];
   lim_type          joint_lim [JOINTS];
   joint_result_type pulse_q [$];

   function automatic logic [10:0] saturate_angle(input logic [10:0] v);
      return (v > FULL_SCALE) ? FULL_SCALE : v;
   endfunction

   always @(posedge clock) begin
      joint_result_type want;
      int unsigned      a;
      int unsigned      pos;
      int unsigned      span;
      if (reset) begin
         pwm_min_q  = PWM_MIN_RESET;
         pwm_max_q  = PWM_MAX_RESET;
         max_step_q = MAX_STEP_RESET;
         for (int i = 0; i < JOINTS; i++) begin
            cur_angle[i] = ANGLE_RESET;
            tgt_angle[i] = ANGLE_RESET;
            joint_lim[i] = LIM_RESET;
         end
         pulse_q.delete();
         errors   = 0;
         compared = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pulse_q.size() == 0) begin
               errors++;
               $error("rsp transfer with nothing expected: out_joint %0d", rsp_out_joint);
            end else begin
               want = pulse_q.pop_front();
               compared++;
               if (rsp_out_joint !== want.joint) begin
                  errors++;
                  $error("out_joint mismatch: expected %0d, actual %0d",
                         want.joint, rsp_out_joint);
               end
               if (rsp_out_channel !== want.channel) begin
                  errors++;
                  $error("out_channel mismatch: expected %0d, actual %0d",
                         want.channel, rsp_out_channel);
               end
               if (rsp_pulse !== want.pulse) begin
                  errors++;
                  $error("pulse mismatch: expected %0d, actual %0d", want.pulse, rsp_pulse);
               end
               if (rsp_driven !== want.driven) begin
                  errors++;
                  $error("driven mismatch: expected %0d, actual %0d", want.driven, rsp_driven);
               end
               if (rsp_last !== want.last) begin
                  errors++;
                  $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
               end
            end
         end

         if (csr_wr_en) begin
            case (csr_index)
               CSR_PWM_MIN:  pwm_min_q  = csr_wdata;
               CSR_PWM_MAX:  pwm_max_q  = csr_wdata;
               CSR_MAX_STEP: max_step_q = csr_wdata[10:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            case (req_cmd)
               CMD_TARGET: begin
                  if (req_joint < JOINTS)
                     tgt_angle[req_joint] = saturate_angle(req_angle);
               end
               CMD_LIMITS: begin
                  if (req_joint < JOINTS)
                     joint_lim[req_joint] = '{low: saturate_angle(req_limit_low),
                                              high: saturate_angle(req_limit_high),
                                              mirrored: req_reversed,
                                              wired: req_present,
                                              channel: req_channel};
               end
               CMD_TICK: begin
                  span = (pwm_max_q > pwm_min_q) ? pwm_max_q - pwm_min_q : 0;
                  for (int i = 0; i < JOINTS; i++) begin
                     // slew toward target, stored angle stays unclamped
                     pos = cur_angle[i];
                     a   = tgt_angle[i];
                     if (a >= pos)
                        pos = (a - pos <= max_step_q) ? a : pos + max_step_q;
                     else
                        pos = (pos - a <= max_step_q) ? a : pos - max_step_q;
                     cur_angle[i] = 11'(pos);
                     a = pos;
                     if (a < joint_lim[i].low)
                        a = joint_lim[i].low;
                     else if (a > joint_lim[i].high)
                        a = joint_lim[i].high;
                     if (joint_lim[i].mirrored)
                        a = FULL_SCALE - a;
                     want.joint   = 5'(i);
                     want.channel = joint_lim[i].channel;
                     want.pulse   = joint_lim[i].wired ?
                                    12'(pwm_min_q + a * span / FULL_SCALE) : 12'd0;
                     want.driven  = joint_lim[i].wired;
                     want.last    = (i == JOINTS - 1);
                     pulse_q.push_back(want);
                  end
               end
               default: ;
            endcase
         end
      end
      pending <= pulse_q.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import jslsp_pkg::*;

   localparam int          JOINTS             = 18;
   localparam logic [1:0]  CMD_UNKNOWN        = 2'd3;
   localparam int unsigned QUIET_LIMIT        = 2000;
   localparam int unsigned SETTLE_CYCLES      = 16;
   localparam int unsigned RANDOM_PER_SETTING = 34;
   localparam int          SETTINGS_COUNT     = 7;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [4:0]  joint;
      logic [10:0] angle;
      logic [10:0] limit_low;
      logic [10:0] limit_high;
      logic        reversed;
      logic        present;
      logic [3:0]  channel;
   } servo_cmd_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY
   } stall_mode_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        csr_wr_en      = 1'b0;
   logic [1:0]  csr_index      = CSR_PWM_MIN;
   logic [11:0] csr_wdata      = '0;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd        = CMD_TICK;
   logic [4:0]  req_joint      = '0;
   logic [10:0] req_angle      = '0;
   logic [10:0] req_limit_low  = '0;
   logic [10:0] req_limit_high = '0;
   logic        req_reversed   = 1'b0;
   logic        req_present    = 1'b0;
   logic [3:0]  req_channel    = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [4:0]  rsp_out_joint;
   logic [3:0]  rsp_out_channel;
   logic [11:0] rsp_pulse;
   logic        rsp_driven;
   logic        rsp_last;

   int unsigned errors;
   int unsigned pending;
   int unsigned compared;

   int unsigned    ticks_sent    = 0;
   int unsigned    targets_sent  = 0;
   int unsigned    loads_sent    = 0;
   int unsigned    ignored_sent  = 0;
   int unsigned    settings_used = 1;
   int unsigned    burst_left    = 0;
   int unsigned    quiet_cycles  = 0;
   int unsigned    stall_run     = 0;
   stall_mode_type stall_mode    = STALL_NONE;

   joint_slew_limit_servo_pwm #(.JOINTS(JOINTS)) DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_joint(req_joint), .req_angle(req_angle), .req_limit_low(req_limit_low),
      .req_limit_high(req_limit_high), .req_reversed(req_reversed),
      .req_present(req_present), .req_channel(req_channel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_joint(rsp_out_joint),
      .rsp_out_channel(rsp_out_channel), .rsp_pulse(rsp_pulse),
      .rsp_driven(rsp_driven), .rsp_last(rsp_last)
   );

   joint_pulse_checker #(.JOINTS(JOINTS)) servo_monitor (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_joint(req_joint), .req_angle(req_angle), .req_limit_low(req_limit_low),
      .req_limit_high(req_limit_high), .req_reversed(req_reversed),
      .req_present(req_present), .req_channel(req_channel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_joint(rsp_out_joint),
      .rsp_out_channel(rsp_out_channel), .rsp_pulse(rsp_pulse),
      .rsp_driven(rsp_driven), .rsp_last(rsp_last),
      .errors(errors), .pending(pending), .compared(compared)
   );

   always #2 clock = ~clock;

   // receiver stall pattern, switching style at random after each random-length run
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_run  <= $urandom_range(10, 120);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= stall_run[3];
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic servo_cmd_type cmd_item(input logic [1:0] cmd, input logic [4:0] joint,
                                              input logic [10:0] angle, input logic [10:0] lo,
                                              input logic [10:0] hi, input logic rev,
                                              input logic pres, input logic [3:0] ch);
      servo_cmd_type c;
      c = '{cmd: cmd, joint: joint, angle: angle, limit_low: lo, limit_high: hi,
            reversed: rev, present: pres, channel: ch};
      return c;
   endfunction

   function automatic servo_cmd_type random_command();
      servo_cmd_type c;
      int unsigned   pick;
      pick = $urandom_range(0, 99);
      c.joint = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(JOINTS, 31))
                                            : 5'($urandom_range(0, JOINTS - 1));
      c.angle = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(1801, 2047))
                                            : 11'($urandom_range(0, 1800));
      if ($urandom_range(0, 5) == 0) begin
         c.limit_low  = 11'($urandom_range(0, 2047));
         c.limit_high = 11'($urandom_range(0, 2047));
      end else begin
         c.limit_low  = 11'($urandom_range(0, 900));
         c.limit_high = 11'($urandom_range(900, 1800));
      end
      c.reversed = 1'($urandom);
      c.present  = ($urandom_range(0, 3) != 0);
      c.channel  = 4'($urandom);
      if (pick < 22)
         c.cmd = CMD_TICK;
      else if (pick < 62)
         c.cmd = CMD_TARGET;
      else if (pick < 92)
         c.cmd = CMD_LIMITS;
      else
         c.cmd = CMD_UNKNOWN;
      return c;
   endfunction

   task automatic send(input servo_cmd_type c);
      req_valid      <= 1'b1;
      req_cmd        <= c.cmd;
      req_joint      <= c.joint;
      req_angle      <= c.angle;
      req_limit_low  <= c.limit_low;
      req_limit_high <= c.limit_high;
      req_reversed   <= c.reversed;
      req_present    <= c.present;
      req_channel    <= c.channel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (c.cmd == CMD_TICK)
         ticks_sent++;
      else if (c.cmd == CMD_UNKNOWN || c.joint >= JOINTS)
         ignored_sent++;
      else if (c.cmd == CMD_TARGET)
         targets_sent++;
      else
         loads_sent++;
   endtask

   // burst of back-to-back transfers, then a random gap
   task automatic pace();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end else begin
         burst_left--;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(input logic [11:0] pmin, input logic [11:0] pmax,
                                    input logic [11:0] step);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PWM_MIN;
      csr_wdata <= pmin;
      @(posedge clock);
      csr_index <= CSR_PWM_MAX;
      csr_wdata <= pmax;
      @(posedge clock);
      csr_index <= CSR_MAX_STEP;
      csr_wdata <= step;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults, limit table and target corner cases, an unknown command
      send(cmd_item(CMD_TICK,    5'd0,  11'd0,    11'd0,    11'd0,    1'b0, 1'b0, 4'd0));
      send(cmd_item(CMD_LIMITS,  5'd0,  11'd0,    11'd300,  11'd1500, 1'b0, 1'b1, 4'd15));
      send(cmd_item(CMD_LIMITS,  5'd1,  11'd0,    11'd1500, 11'd300,  1'b0, 1'b1, 4'd1));
      send(cmd_item(CMD_LIMITS,  5'd2,  11'd0,    11'd0,    11'd1800, 1'b1, 1'b1, 4'd7));
      send(cmd_item(CMD_LIMITS,  5'd17, 11'd0,    11'd2047, 11'd2047, 1'b1, 1'b1, 4'd8));
      send(cmd_item(CMD_LIMITS,  5'd3,  11'd0,    11'd0,    11'd1800, 1'b0, 1'b0, 4'd5));
      send(cmd_item(CMD_LIMITS,  5'd18, 11'd0,    11'd100,  11'd200,  1'b1, 1'b1, 4'd9));
      send(cmd_item(CMD_LIMITS,  5'd31, 11'd2047, 11'd2047, 11'd2047, 1'b1, 1'b1, 4'd15));
      send(cmd_item(CMD_TICK,    5'd0,  11'd0,    11'd0,    11'd0,    1'b0, 1'b0, 4'd0));
      send(cmd_item(CMD_TARGET,  5'd0,  11'd0,    11'd0,    11'd0,    1'b0, 1'b0, 4'd0));
      send(cmd_item(CMD_TARGET,  5'd1,  11'd1800, 11'd0,    11'd0,    1'b0, 1'b0, 4'd0));
      send(cmd_item(CMD_TARGET,  5'd2,  11'd2047, 11'd0,    11'd0,    1'b0, 1'b0, 4'd0));
      send(cmd_item(CMD_TARGET,  5'd17, 11'd0,    11'd0,    11'd0,    1'b0, 1'b0, 4'd0));
      send(cmd_item(CMD_TARGET,  5'd31, 11'd1000, 11'd0,    11'd0,    1'b0, 1'b0, 4'd0));
      send(cmd_item(CMD_UNKNOWN, 5'd31, 11'd2047, 11'd2047, 11'd2047, 1'b1, 1'b1, 4'd15));
      send(cmd_item(CMD_LIMITS,  5'd4,  11'd0,    11'd0,    11'd1800, 1'b0, 1'b1, 4'd0));
      send(cmd_item(CMD_TARGET,  5'd4,  11'd1800, 11'd0,    11'd0,    1'b0, 1'b0, 4'd0));
      repeat (5)
         send(cmd_item(CMD_TICK, 5'd0,  11'd0,    11'd0,    11'd0,    1'b0, 1'b0, 4'd0));

      for (int p = 0; p < SETTINGS_COUNT; p++) begin
         settle();
         case (p)
            0: program_registers(12'd0, 12'd4095, 12'd1800);
            1: program_registers(12'd4095, 12'd0, 12'd0);
            2: program_registers(12'd150, 12'd600, 12'd1);
            3: program_registers(12'd600, 12'd150, 12'd37);
            4: program_registers(PWM_MIN_RESET, PWM_MAX_RESET, 12'(MAX_STEP_RESET));
            5: program_registers(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                                 12'($urandom_range(0, 1800)));
            default: program_registers(12'($urandom_range(0, 1000)),
                                       12'($urandom_range(3000, 4095)),
                                       12'($urandom_range(1, 200)));
         endcase
         repeat (RANDOM_PER_SETTING) begin
            send(random_command());
            pace();
         end
      end

      settle();
      $display("covered %0d ticks, %0d target writes, %0d limit loads, %0d ignored commands",
               ticks_sent, targets_sent, loads_sent, ignored_sent);
      $display("over %0d register settings incl. inverted span and step extremes; %0d results",
               settings_used, compared);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### joint_slew_limit_servo_pwm.f
design/jslsp_pkg.sv
design/jslsp_ctrl.sv
design/jslsp_dpath.sv
design/joint_slew_limit_servo_pwm.sv
verif/joint_pulse_checker.sv
verif/tb.sv
